FILE: hdl/msc_pkg.sv
package msc_pkg;

  // Line buffer limit, terminator slot included
  localparam int unsigned MaxLine = 64;
  localparam int unsigned LenW    = $clog2(MaxLine);

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharX     = 8'h78;

  localparam logic [0:0] CfgDirMin = 1'b0;
  localparam logic [0:0] CfgDirMax = 1'b1;

  localparam logic [7:0] DirMinRst = 8'd0;
  localparam logic [7:0] DirMaxRst = 8'd2;

  // Classified character as held in the queue
  typedef struct packed {
    logic [7:0] chr;
    logic       is_cr;
    logic       is_nul;
    logic       is_space;
    logic       hex_ok;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic [7:0] dir_min;
    logic [7:0] dir_max;
  } cfg_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [7:0] m3_spd;
    logic [7:0] m3_dir;
    logic [7:0] m2_spd;
    logic [7:0] m2_dir;
    logic       status;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h53; // S
      3'd1:    c = 8'h50; // P
      3'd2:    c = 8'h45; // E
      3'd3:    c = 8'h45; // E
      3'd4:    c = 8'h44; // D
      3'd5:    c = 8'h53; // S
      3'd6:    c = 8'h32; // 2
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/msc_front.sv
module msc_front
  import msc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_i,
  input  logic [7:0] chr_i,
  output logic       push_o,
  output item_t      item_o
);

  logic [LenW-1:0] len_q, len_d;
  logic            is_cr;
  logic            room;

  assign is_cr = (chr_i == CharCr);
  assign room  = (len_q < LenW'(MaxLine - 1));

  // Classify the character
  always_comb begin
    item_o.chr      = chr_i;
    item_o.is_cr    = is_cr;
    item_o.is_nul   = (chr_i == 8'h00);
    item_o.is_space = (chr_i == CharSpace);
    item_o.hex_ok   = 1'b0;
    item_o.hex_val  = 4'd0;
    if (chr_i >= 8'h30 && chr_i <= 8'h39) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(chr_i - 8'h30);
    end else if (chr_i >= 8'h61 && chr_i <= 8'h66) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(chr_i - 8'h57);
    end else if (chr_i >= 8'h41 && chr_i <= 8'h46) begin
      item_o.hex_ok  = 1'b1;
      item_o.hex_val = 4'(chr_i - 8'h37);
    end
  end

  // Drop characters past the line limit; carriage return always passes
  assign push_o = req_i && (is_cr || room);

  always_comb begin
    len_d = len_q;
    if (req_i) begin
      if (is_cr) begin
        len_d = '0;
      end else if (room) begin
        len_d = len_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

FILE: hdl/msc_fifo.sv
module msc_fifo
  import msc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      item_i,
  input  logic       pop_i,
  output item_t      head_o,
  output fifo_stat_t stat_o
);

  item_t           mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/msc_back.sv
module msc_back
  import msc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  item_t      head_i,
  output logic       pop_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  localparam logic [4:0] PhNum0 = 5'd7;
  localparam logic [4:0] PhDone = 5'd23;
  localparam logic [4:0] PhErr  = 5'd24;

  logic [4:0] ph_q, ph_d;
  logic [7:0] hi_q, hi_d;
  logic [7:0] pd2_q, pd2_d, ps2_q, ps2_d, pd3_q, pd3_d;
  logic [7:0] ad2_q, ad2_d, as2_q, as2_d, ad3_q, ad3_d, as3_q, as3_d;
  logic       out_vld_q, out_vld_d;
  result_t    out_q, out_d;

  logic [4:0] rel;
  logic [1:0] sub;
  logic [1:0] num;
  logic [7:0] val;
  logic       is_dir;
  logic       in_range;
  logic       load;

  assign rel      = ph_q - PhNum0;
  assign sub      = rel[1:0];
  assign num      = rel[3:2];
  assign val      = hi_q | {4'd0, head_i.hex_val};
  assign is_dir   = !num[0];
  assign in_range = (val >= cfg_i.dir_min) && (val <= cfg_i.dir_max);

  // A carriage return waits until the result slot is free
  assign pop_o = head_valid_i && (!head_i.is_cr || !out_vld_q || res_ready_i);
  assign load  = pop_o && head_i.is_cr;

  always_comb begin
    ph_d  = ph_q;
    hi_d  = hi_q;
    pd2_d = pd2_q;
    ps2_d = ps2_q;
    pd3_d = pd3_q;
    ad2_d = ad2_q;
    as2_d = as2_q;
    ad3_d = ad3_q;
    as3_d = as3_q;
    out_d = out_q;
    out_vld_d = out_vld_q && !res_ready_i;
    if (load) begin
      if (ph_q == PhDone) begin
        ad2_d = pd2_q;
        as2_d = ps2_q;
        ad3_d = pd3_q;
        as3_d = hi_q;
      end
      out_d.status = (ph_q != PhDone);
      out_d.m2_dir = (ph_q == PhDone) ? pd2_q : ad2_q;
      out_d.m2_spd = (ph_q == PhDone) ? ps2_q : as2_q;
      out_d.m3_dir = (ph_q == PhDone) ? pd3_q : ad3_q;
      out_d.m3_spd = (ph_q == PhDone) ? hi_q  : as3_q;
      out_vld_d    = 1'b1;
      ph_d         = '0;
    end else if (pop_o && ph_q < PhDone) begin
      if (head_i.is_nul) begin
        ph_d = PhErr;
      end else if (ph_q < PhNum0) begin
        ph_d = (head_i.chr == prefix_char(ph_q[2:0])) ? ph_q + 5'd1 : PhErr;
      end else begin
        unique case (sub)
          2'd0: begin
            // Skip leading spaces
            if (!head_i.is_space) begin
              ph_d = (head_i.chr == CharZero) ? ph_q + 5'd1 : PhErr;
            end
          end
          2'd1: ph_d = (head_i.chr == CharX) ? ph_q + 5'd1 : PhErr;
          2'd2: begin
            if (head_i.hex_ok) begin
              hi_d = {head_i.hex_val, 4'd0};
              ph_d = ph_q + 5'd1;
            end else begin
              ph_d = PhErr;
            end
          end
          default: begin
            if (!head_i.hex_ok || (is_dir && !in_range)) begin
              ph_d = PhErr;
            end else begin
              unique case (num)
                2'd0:    pd2_d = val;
                2'd1:    ps2_d = val;
                2'd2:    pd3_d = val;
                default: hi_d  = val;
              endcase
              ph_d = ph_q + 5'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= '0;
      hi_q      <= '0;
      pd2_q     <= '0;
      ps2_q     <= '0;
      pd3_q     <= '0;
      ad2_q     <= '0;
      as2_q     <= '0;
      ad3_q     <= '0;
      as3_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      ph_q      <= ph_d;
      hi_q      <= hi_d;
      pd2_q     <= pd2_d;
      ps2_q     <= ps2_d;
      pd3_q     <= pd3_d;
      ad2_q     <= ad2_d;
      as2_q     <= as2_d;
      ad3_q     <= ad3_d;
      as3_q     <= as3_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

FILE: hdl/motor_speed_command_parser.sv
// Motor speed command parser. Feed received characters one per request on the
// slave stream; a line ending in carriage return gives one result on the master
// stream: status 0 when the line read SPEEDS2 and four numbers of the form 0x
// and two hex digits (spaces may lead each number, both directions inside
// [direction_min, direction_max]), status 1 otherwise, plus the applied motor
// settings, which change only on status 0. A character is taken every cycle
// while the four-entry queue between the classifier and the parser has room;
// the parser drains one entry a cycle unless a carriage return is held back, so
// the sustained rate is one character per cycle while results are taken. The
// parser registers each result from its carriage return, and a carriage
// return only stalls the parser while the previous result is still waiting on
// the master side. No clearing pass follows reset.
module motor_speed_command_parser
  import msc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // Characters in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] status, [8:1] motor2_direction,
                                      // [16:9] motor2_speed, [24:17] motor3_direction,
                                      // [32:25] motor3_speed, [39:33] zero
);

  cfg_t       cfg_q;
  item_t      fr_item;
  logic       fr_push;
  item_t      head;
  fifo_stat_t fstat;
  logic       pop;
  result_t    res;
  logic       s_req;

  // Hold the direction bounds; the user must write only while idle; not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_min <= DirMinRst;
      cfg_q.dir_max <= DirMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDirMin: cfg_q.dir_min <= cfg_data_i;
        default:   cfg_q.dir_max <= cfg_data_i;
      endcase
    end
  end

  assign s_axis_tready = !fstat.full;
  assign s_req         = s_axis_tvalid && s_axis_tready;

  // Front: classify and enforce the line limit
  msc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (s_req),
    .chr_i  (s_axis_tdata),
    .push_o (fr_push),
    .item_o (fr_item)
  );

  msc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .item_i (fr_item),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fstat)
  );

  // Back: advance the parse and register the result
  msc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (!fstat.empty),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {7'd0, res};

  // A result only ever follows the parser taking a carriage return
  a_res_from_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop && head.is_cr))
    else $error("result raised without a carriage return");

  // A waiting result blocks the next carriage return
  a_cr_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && head.is_cr && m_axis_tvalid && !m_axis_tready))
    else $error("carriage return popped over a waiting result");

  // A carriage return is never dropped by the front
  a_cr_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_req && s_axis_tdata == CharCr) |=> !fstat.empty)
    else $error("carriage return lost before the queue");

endmodule
